// ----- rtl/palette_nearest_color_map_unit_assert.svh -----
// Assertion macros for the palette nearest-color map unit.
`ifndef PALETTE_NEAREST_COLOR_MAP_UNIT_ASSERT_SVH
`define PALETTE_NEAREST_COLOR_MAP_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off during reset
`define PNCM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PNCM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PNCM_ASSERT_IMP(lbl, ante, cons, msg)
`define PNCM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/pncm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the palette nearest-color map unit.
package pncm_pkg;

	localparam int CH_W     = 8;
	localparam int ENTRY_W  = 3 * CH_W;
	localparam int DIST_W   = 18;
	localparam int SQ_W     = 2 * CH_W;
	localparam int C5_W     = 5;
	localparam int S_DATA_W = 48;
	localparam int RES_W    = 58;
	localparam int M_DATA_W = 64;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

	// low bits of a 5-bit channel widened to 8: (c << 3) + 4
	localparam logic [2:0] EXPAND_LSBS = 3'b100;

	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

endpackage

// ----- rtl/pncm_chan_cell.sv -----
`timescale 1ns / 1ps
// One channel cell: adds the squared difference of one color byte to the running distance.
module pncm_chan_cell #(
	parameter int IDX_W = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_load,
	input  logic [pncm_pkg::CH_W-1:0]        q_byte,
	input  pncm_pkg::ctl_t                   ctl_in,
	input  logic [IDX_W-1:0]                 idx_in,
	input  logic [pncm_pkg::ENTRY_W-1:0]     entry_in,
	input  logic [pncm_pkg::DIST_W-1:0]      sum_in,
	output pncm_pkg::ctl_t                   ctl_out,
	output logic [IDX_W-1:0]                 idx_out,
	output logic [pncm_pkg::ENTRY_W-1:0]     entry_out,
	output logic [pncm_pkg::DIST_W-1:0]      sum_out
);
	import pncm_pkg::*;

	logic [CH_W-1:0]    q_q;
	logic [CH_W-1:0]    e_byte;
	logic [CH_W-1:0]    diff;
	logic [SQ_W-1:0]    sq;
	ctl_t               ctl_q;
	logic [IDX_W-1:0]   idx_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [DIST_W-1:0]  sum_q;

	// this cell always works on the low byte; the rest moves down for the next cell
	assign e_byte = entry_in[CH_W-1:0];
	assign diff   = (q_q > e_byte) ? (q_q - e_byte) : (e_byte - q_q);
	assign sq     = diff * diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (q_load) begin
			q_q <= q_byte;
		end
		idx_q   <= idx_in;
		entry_q <= {CH_W'(0), entry_in[ENTRY_W-1:CH_W]};
		sum_q   <= sum_in + DIST_W'(sq);
	end

	assign ctl_out   = ctl_q;
	assign idx_out   = idx_q;
	assign entry_out = entry_q;
	assign sum_out   = sum_q;

endmodule

// ----- rtl/pncm_min_track.sv -----
`timescale 1ns / 1ps
// Running minimum over the distance stream; lowest index kept on ties.
module pncm_min_track #(
	parameter int IDX_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  pncm_pkg::ctl_t              ctl_in,
	input  logic [IDX_W-1:0]            idx_in,
	input  logic [pncm_pkg::DIST_W-1:0] dist_in,
	output logic                        done,
	output logic [IDX_W-1:0]            best_idx,
	output logic [pncm_pkg::DIST_W-1:0] best_dist
);
	import pncm_pkg::*;

	logic              have_q;
	logic              done_q;
	logic              take;
	logic [IDX_W-1:0]  best_idx_q;
	logic [DIST_W-1:0] best_dist_q;

	// strict compare: entries arrive in index order, so the earlier one wins a tie
	assign take = ctl_in.valid && (!have_q || (dist_in < best_dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_in.valid && ctl_in.last;
			if (start) begin
				have_q <= 1'b0;
			end else if (ctl_in.valid) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= idx_in;
			best_dist_q <= dist_in;
		end
	end

	assign done      = done_q;
	assign best_idx  = best_idx_q;
	assign best_dist = best_dist_q;

endmodule

// ----- rtl/palette_nearest_color_map_unit.sv -----
`timescale 1ns / 1ps
// Palette nearest-color map unit: palette store plus nearest-entry search.
// Input beats on s_* (tuser = cmd). cmd 0 loads a palette entry and returns its
// packed 32-bit word (alpha 255, or 0 for the last entry). cmd 1 carries an RGB555
// color and returns the index and squared distance of the closest palette entry.
// Every input beat gives exactly one output beat on m_*, in order.
// s_tready stays low until a load result has left the result register. During a query,
// from acceptance to m_tvalid, the palette memory is read one entry per cycle and
// each entry passes a chain of three channel cells (one per color byte) that build
// the distance, then a running-minimum stage. One item is in work at a time.
// Results wait in a result register and an output register, so a new beat can be
// accepted while the previous result is held by a stalled receiver; when both are
// full, s_tready stays low until m_tready takes a beat.
// Reset clears all control state; palette contents are undefined until loaded and
// a query is only meaningful once every entry has been written.
`include "palette_nearest_color_map_unit_assert.svh"
module palette_nearest_color_map_unit #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue, [46:32] color15
	input  logic [pncm_pkg::S_DATA_W-1:0] s_tdata,
	// [0] cmd
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] packed_entry, [39:32] best_index, [57:40] best_distance
	output logic [pncm_pkg::M_DATA_W-1:0] m_tdata
);
	import pncm_pkg::*;

	localparam int IDX_W = $clog2(PALETTE_ENTRIES);

	state_t state_q, state_d;

	logic [CH_W-1:0]  in_entry_index;
	logic [CH_W-1:0]  in_red;
	logic [CH_W-1:0]  in_green;
	logic [CH_W-1:0]  in_blue;
	logic [14:0]      in_color15;

	logic s_accept, load_acc, query_acc;
	logic in_range, mem_we;
	logic [IDX_W-1:0] waddr;
	logic [CH_W-1:0]  alpha;
	logic [RES_W-1:0] load_res, query_res;

	logic ready_c, rd_en, drain_done, last_issue;
	logic [IDX_W-1:0] addr_q;

	logic [ENTRY_W-1:0] pal_mem [PALETTE_ENTRIES];

	ctl_t               ctl_c   [4];
	logic [IDX_W-1:0]   idx_c   [4];
	logic [ENTRY_W-1:0] entry_c [3];
	logic [DIST_W-1:0]  sum_c   [4];
	logic [CH_W-1:0]    q_chan  [3];

	logic              trk_done;
	logic [IDX_W-1:0]  trk_idx;
	logic [DIST_W-1:0] trk_dist;

	logic             res_valid_q, out_valid_q, res_set, move;
	logic [RES_W-1:0] res_q, out_q;

	assign in_entry_index = s_tdata[7:0];
	assign in_red         = s_tdata[15:8];
	assign in_green       = s_tdata[23:16];
	assign in_blue        = s_tdata[31:24];
	assign in_color15     = s_tdata[46:32];

	assign s_accept  = s_tvalid && s_tready;
	assign load_acc  = s_accept && (s_tuser == CMD_LOAD);
	assign query_acc = s_accept && (s_tuser == CMD_QUERY);

	// load path
	assign in_range = 32'(in_entry_index) < PALETTE_ENTRIES;
	assign mem_we   = load_acc && in_range;
	assign waddr    = IDX_W'(in_entry_index);
	assign alpha    = (in_range && (32'(in_entry_index) == PALETTE_ENTRIES - 1)) ?
			ALPHA_CLEAR : ALPHA_OPAQUE;
	assign load_res = RES_W'({alpha, in_blue, in_green, in_red});

	// FSM
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (query_acc) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (last_issue) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (trk_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ready_c    = 1'b0;
		rd_en      = 1'b0;
		drain_done = 1'b0;
		case (state_q)
			ST_IDLE:  ready_c    = !res_valid_q;
			ST_SCAN:  rd_en      = 1'b1;
			ST_DRAIN: drain_done = trk_done;
			default: begin
				ready_c = 1'b0;
			end
		endcase
	end

	assign s_tready   = ready_c;
	assign last_issue = rd_en && (addr_q == IDX_W'(PALETTE_ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			addr_q   <= '0;
			ctl_c[0] <= '0;
		end else begin
			state_q <= state_d;
			if (query_acc) begin
				addr_q <= '0;
			end else if (rd_en) begin
				addr_q <= addr_q + IDX_W'(1);
			end
			ctl_c[0].valid <= rd_en;
			ctl_c[0].last  <= last_issue;
		end
	end

	// palette memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pal_mem[waddr] <= {in_blue, in_green, in_red};
		end
		if (rd_en) begin
			entry_c[0] <= pal_mem[addr_q];
		end
		idx_c[0] <= addr_q;
	end

	assign sum_c[0] = '0;

	// query channels widened to 8 bits: red, green, blue
	assign q_chan[0] = {in_color15[4:0],   EXPAND_LSBS};
	assign q_chan[1] = {in_color15[9:5],   EXPAND_LSBS};
	assign q_chan[2] = {in_color15[14:10], EXPAND_LSBS};

	pncm_chan_cell #(.IDX_W(IDX_W)) u_cell_red (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_load    (query_acc),
		.q_byte    (q_chan[0]),
		.ctl_in    (ctl_c[0]),
		.idx_in    (idx_c[0]),
		.entry_in  (entry_c[0]),
		.sum_in    (sum_c[0]),
		.ctl_out   (ctl_c[1]),
		.idx_out   (idx_c[1]),
		.entry_out (entry_c[1]),
		.sum_out   (sum_c[1])
	);

	pncm_chan_cell #(.IDX_W(IDX_W)) u_cell_green (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_load    (query_acc),
		.q_byte    (q_chan[1]),
		.ctl_in    (ctl_c[1]),
		.idx_in    (idx_c[1]),
		.entry_in  (entry_c[1]),
		.sum_in    (sum_c[1]),
		.ctl_out   (ctl_c[2]),
		.idx_out   (idx_c[2]),
		.entry_out (entry_c[2]),
		.sum_out   (sum_c[2])
	);

	pncm_chan_cell #(.IDX_W(IDX_W)) u_cell_blue (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_load    (query_acc),
		.q_byte    (q_chan[2]),
		.ctl_in    (ctl_c[2]),
		.idx_in    (idx_c[2]),
		.entry_in  (entry_c[2]),
		.sum_in    (sum_c[2]),
		.ctl_out   (ctl_c[3]),
		.idx_out   (idx_c[3]),
		.entry_out (),
		.sum_out   (sum_c[3])
	);

	pncm_min_track #(.IDX_W(IDX_W)) u_min_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (query_acc),
		.ctl_in    (ctl_c[3]),
		.idx_in    (idx_c[3]),
		.dist_in   (sum_c[3]),
		.done      (trk_done),
		.best_idx  (trk_idx),
		.best_dist (trk_dist)
	);

	assign query_res = {trk_dist, CH_W'(trk_idx), 32'd0};

	// result register, then output register
	assign res_set = load_acc || drain_done;
	assign move    = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (move) begin
				res_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= res_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_acc) begin
			res_q <= load_res;
		end else if (drain_done) begin
			res_q <= query_res;
		end
		if (move && res_valid_q) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_DATA_W'(out_q);

	`PNCM_ASSERT_IMP(a_done_in_drain, trk_done, state_q == ST_DRAIN, "search done outside drain")
	`PNCM_ASSERT_IMP(a_res_no_overwrite, res_set, !res_valid_q, "result register overwritten")
	`PNCM_ASSERT_NXT(a_scan_from_zero, query_acc, (state_q == ST_SCAN) && (addr_q == '0),
		"scan did not start at entry zero")

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the palette nearest-color map unit.
module tb_top;
	import pncm_pkg::*;

	localparam int PALETTE_ENTRIES = 256;
	localparam int RANDOM_BEATS    = 930;
	localparam int TAIL_BEATS      = 150;
	localparam int STALL_AT_RESULT = 258;
	localparam int STALL_CYCLES    = 500;
	localparam int DRAIN_CYCLES    = 300;

	typedef struct {
		logic        cmd;
		logic [7:0]  entry_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [14:0] color15;
	} palette_cmd_t;

	typedef struct {
		logic [31:0] packed_entry;
		logic [7:0]  best_index;
		logic [17:0] best_distance;
	} map_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	palette_cmd_t  palette_cmd_q[$];
	map_result_t   expected_map_q[$];
	logic [23:0]   palette_shadow[PALETTE_ENTRIES];
	palette_cmd_t  offered_cmd;
	logic          tail_quiet = 1'b0;
	int            error_count = 0;
	int            src_idle = 0;
	int            src_idle_pct = 10;
	int            accepted_beats = 0;
	int            sink_idle = 0;
	int            sink_idle_pct = 10;
	int            results_seen = 0;
	int            stall_left = 0;

	palette_nearest_color_map_unit #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int idle_pct_pick();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 40;
		endcase
	endfunction

	// unused fields carry junk; the block must ignore them
	task automatic push_load(input logic [7:0] idx, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		palette_cmd_t c;
		c.cmd         = CMD_LOAD;
		c.entry_index = idx;
		c.red         = r;
		c.green       = g;
		c.blue        = b;
		c.color15     = 15'($urandom);
		palette_cmd_q.push_back(c);
	endtask

	task automatic push_query(input logic [14:0] c15);
		palette_cmd_t c;
		c.cmd         = CMD_QUERY;
		c.entry_index = 8'($urandom);
		c.red         = 8'($urandom);
		c.green       = 8'($urandom);
		c.blue        = 8'($urandom);
		c.color15     = c15;
		palette_cmd_q.push_back(c);
	endtask

	function automatic int unsigned sq_gap(input logic [7:0] a, input logic [7:0] b);
		int unsigned d;
		d = (a > b) ? int'(a - b) : int'(b - a);
		return d * d;
	endfunction

	// full scan, strict less-than so the lowest index keeps a tie
	function automatic map_result_t nearest_entry(input logic [14:0] c15);
		map_result_t res;
		logic [7:0]  qr, qg, qb;
		int unsigned best_d;
		int unsigned d;
		int          best_i;
		qr = {c15[4:0], EXPAND_LSBS};
		qg = {c15[9:5], EXPAND_LSBS};
		qb = {c15[14:10], EXPAND_LSBS};
		best_d = 32'hFFFF_FFFF;
		best_i = 0;
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			d = sq_gap(qr, palette_shadow[i][7:0]) + sq_gap(qg, palette_shadow[i][15:8])
				+ sq_gap(qb, palette_shadow[i][23:16]);
			if (d < best_d) begin
				best_d = d;
				best_i = i;
			end
		end
		res.packed_entry  = '0;
		res.best_index    = 8'(best_i);
		res.best_distance = 18'(best_d);
		return res;
	endfunction

	task automatic apply_palette_beat(input palette_cmd_t c);
		map_result_t res;
		logic [7:0]  alpha;
		if (c.cmd == CMD_LOAD) begin
			alpha = ALPHA_OPAQUE;
			if (int'(c.entry_index) < PALETTE_ENTRIES) begin
				palette_shadow[c.entry_index] = {c.blue, c.green, c.red};
				if (int'(c.entry_index) == PALETTE_ENTRIES - 1)
					alpha = ALPHA_CLEAR;
			end
			res.packed_entry  = {alpha, c.blue, c.green, c.red};
			res.best_index    = '0;
			res.best_distance = '0;
		end else begin
			res = nearest_entry(c.color15);
		end
		expected_map_q.push_back(res);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				apply_palette_beat(offered_cmd);
				accepted_beats++;
				if (accepted_beats % 64 == 0)
					src_idle_pct = idle_pct_pick();
			end
			tail_quiet <= (palette_cmd_q.size() < TAIL_BEATS);
			if (!s_tvalid || s_tready) begin
				if (src_idle > 0) begin
					src_idle--;
					s_tvalid <= 1'b0;
				end else if (palette_cmd_q.size() != 0) begin
					offered_cmd = palette_cmd_q.pop_front();
					s_tdata  <= {1'b0, offered_cmd.color15, offered_cmd.blue,
						offered_cmd.green, offered_cmd.red, offered_cmd.entry_index};
					s_tuser  <= offered_cmd.cmd;
					s_tvalid <= 1'b1;
					if (!tail_quiet && $urandom_range(0, 99) < src_idle_pct)
						src_idle = $urandom_range(1, 14);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and sink
	always @(posedge clk) begin
		map_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_map_q.size() == 0) begin
					$display("%0t: unexpected beat, actual %h", $time, m_tdata);
					error_count++;
				end else begin
					want = expected_map_q.pop_front();
					if (m_tdata[31:0] !== want.packed_entry) begin
						$display("%0t: packed_entry expected %h actual %h", $time,
							want.packed_entry, m_tdata[31:0]);
						error_count++;
					end
					if (m_tdata[39:32] !== want.best_index) begin
						$display("%0t: best_index expected %0d actual %0d", $time,
							want.best_index, m_tdata[39:32]);
						error_count++;
					end
					if (m_tdata[57:40] !== want.best_distance) begin
						$display("%0t: best_distance expected %0d actual %0d", $time,
							want.best_distance, m_tdata[57:40]);
						error_count++;
					end
				end
				results_seen++;
				// long hold-off while the palette refill streams in
				if (results_seen == STALL_AT_RESULT)
					stall_left = STALL_CYCLES;
				if (results_seen % 64 == 0)
					sink_idle_pct = idle_pct_pick();
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (sink_idle > 0) begin
				sink_idle--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!tail_quiet && $urandom_range(0, 99) < sink_idle_pct)
					sink_idle = $urandom_range(1, 14);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		logic [7:0] r, g, b;
		// all white first: far corner gives the large distances
		for (int i = 0; i < PALETTE_ENTRIES; i++)
			push_load(8'(i), 8'hFF, 8'hFF, 8'hFF);
		push_query(15'h0000);
		push_query(15'h7FFF);

		// refill, dark corner kept clear except for entry 0 and the tie entries
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			case (i)
				0:   push_load(8'(i), 8'h00, 8'h00, 8'h00);
				3:   push_load(8'(i), 8'h00, 8'h04, 8'h04);
				7:   push_load(8'(i), 8'h08, 8'h04, 8'h04);
				128: push_load(8'(i), 8'hAA, 8'h55, 8'hAA);
				200: push_load(8'(i), 8'd100, 8'd148, 8'd196);
				201: push_load(8'(i), 8'd100, 8'd148, 8'd196);
				255: push_load(8'(i), 8'hFF, 8'hFF, 8'hFF);
				default: push_load(8'(i), 8'($urandom_range(16, 255)),
					8'($urandom_range(16, 255)), 8'($urandom_range(16, 255)));
			endcase
		end

		// equal distance from entries 3 and 7: lower index wins
		push_query(15'h0000);
		// exact hit shared by entries 200 and 201
		push_query({5'd24, 5'd18, 5'd12});
		push_query(15'h7FFF);
		push_query(15'h001F);
		push_query(15'h03E0);
		push_query(15'h7C00);
		push_query(15'h5555);
		push_query(15'h2AAA);

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if ($urandom_range(0, 99) < 40) begin
				r = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom);
				g = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom);
				b = 8'($urandom);
				push_load(8'($urandom), r, g, b);
			end else begin
				case ($urandom_range(0, 19))
					0: push_query(15'h0000);
					1: push_query(15'h7FFF);
					default: push_query(15'($urandom));
				endcase
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (palette_cmd_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_map_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_map_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
